>>> src/lssh_pkg.sv
// ----------------------------------------------------------------------------
// Lowpass-scaled saturating highpass: shared package
// Widths, fixed-point formats, coefficients, payload words and the command
// and status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lssh_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int STATE_WIDTH  = 32;
  localparam int COEF_WIDTH   = 24;

  localparam int WORK_FRAC  = 40;
  localparam int SAMP_FRAC  = SAMPLE_WIDTH - 2;
  localparam int LP_FRAC    = STATE_WIDTH - 2;
  localparam int ERR_FRAC   = STATE_WIDTH - 10;
  localparam int CONST_FRAC = 30;
  localparam int COEF_FRAC  = 24;
  localparam int TERM_FRAC  = ERR_FRAC + CONST_FRAC - WORK_FRAC;

  localparam int WORD_W = 56;
  localparam int HALF_W = 26;
  localparam int OPER_W = 2 * HALF_W;
  localparam int PROD_W = 2 * OPER_W;
  localparam int SH_W   = 6;

  typedef logic signed [WORD_W-1:0]       word_t;
  typedef logic signed [STATE_WIDTH-1:0]  state_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam logic [COEF_WIDTH-1:0] COEF_RESET = COEF_WIDTH'(1048576);

  localparam word_t K_096   = word_t'(1030792151);
  localparam word_t K_SIXTH = word_t'(178956971);
  localparam word_t K_D2    = word_t'(66357245);
  localparam word_t K_D3    = word_t'(64231236);
  localparam word_t K_D4    = word_t'(22119082);
  localparam word_t K_092   = word_t'(987842478);
  localparam word_t ONE_W   = word_t'(1) <<< WORK_FRAC;

  localparam word_t STATE_MAX = (word_t'(1) <<< (STATE_WIDTH - 1)) - word_t'(1);
  localparam word_t STATE_MIN = -(word_t'(1) <<< (STATE_WIDTH - 1));
  localparam word_t SAMP_MAX  = (word_t'(1) <<< (SAMPLE_WIDTH - 1)) - word_t'(1);
  localparam word_t SAMP_MIN  = -(word_t'(1) <<< (SAMPLE_WIDTH - 1));

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LP  = 4'd0;
  localparam logic [OP_W-1:0] OP_K   = 4'd1;
  localparam logic [OP_W-1:0] OP_K2  = 4'd2;
  localparam logic [OP_W-1:0] OP_K3  = 4'd3;
  localparam logic [OP_W-1:0] OP_X2  = 4'd4;
  localparam logic [OP_W-1:0] OP_X4  = 4'd5;
  localparam logic [OP_W-1:0] OP_M   = 4'd6;
  localparam logic [OP_W-1:0] OP_E   = 4'd7;
  localparam logic [OP_W-1:0] OP_T2  = 4'd8;
  localparam logic [OP_W-1:0] OP_T3  = 4'd9;
  localparam logic [OP_W-1:0] OP_T4  = 4'd10;
  localparam logic [OP_W-1:0] OP_RES = 4'd11;
  localparam logic [OP_W-1:0] OP_P92 = 4'd12;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_ES  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_D1  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_D2  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_D3  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_D4  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_BYP = 3'd5;
  localparam logic [STEP_W-1:0] STEP_OUT = 3'd6;

  typedef struct packed {
    sample_t sample_in;
    logic    block_last;
  } sample_word_t;

  typedef struct packed {
    sample_t sample_out;
    logic    block_end;
  } result_word_t;

  typedef struct packed {
    logic              load;
    logic              mul_start;
    logic              wb;
    logic              step_en;
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic lp_zero;
    logic mul_done;
  } dp_status_t;

endpackage

>>> src/lowpass_scaled_saturating_highpass_unit.sv
// ----------------------------------------------------------------------------
// Lowpass-scaled saturating highpass unit
// Top level: controller, datapath and the smoothing coefficient port.
// ----------------------------------------------------------------------------
// Each input word carries one signed Q1.22 sample and a block-end mark. The
// sample updates a one-pole lowpass; when the level is nonzero a cubic-quartic
// error term and its differences scale the sample, and 0.92 of the level is
// then subtracted before the result is saturated to 24 bits.
// Input words are taken on sample_valid with sample_stall low; results leave
// on result_valid with result_stall low. The smoothing coefficient is written
// through cfg_valid and cfg_data, and cfg_ready is always high.
// All products go through one shared multiplier. A new word is taken only
// once the previous result has reached the output register; when the
// updated lowpass level is zero, the error-term products are skipped.
// The finished word sits in an output register, so the block accepts the next
// sample while it waits; a stalled receiver holds that word, and the block
// waits only when a second result is ready before the first has been taken.
// Reset clears the lowpass and difference state, sets the coefficient to 1/16
// and leaves no word pending.
// ----------------------------------------------------------------------------
module lowpass_scaled_saturating_highpass_unit import lssh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_word_t          sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_word_t          result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COEF_WIDTH-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lssh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  lssh_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .sample   (sample),
    .result   (result),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

>>> src/lssh_mul.sv
// ----------------------------------------------------------------------------
// Lowpass-scaled saturating highpass: shared multiplier
// Sign-magnitude multiply built from four half-width partial products, with
// a rounding right shift (ties away from zero) and the sign restored.
// ----------------------------------------------------------------------------
module lssh_mul import lssh_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  word_t           a,
  input  word_t           b,
  input  logic [SH_W-1:0] sh,
  output logic            done,
  output word_t           p
);

  logic                  busy;
  logic [1:0]            cnt;
  logic                  add_v;
  logic                  add_last;
  logic                  fin;
  logic [OPER_W-1:0]     ma;
  logic [OPER_W-1:0]     mb;
  logic                  neg;
  logic [SH_W-1:0]       sh_q;
  logic [2*HALF_W-1:0]   pp;
  logic [1:0]            pp_pos;
  logic [PROD_W-1:0]     acc;
  word_t                 a_abs;
  word_t                 b_abs;
  logic [HALF_W-1:0]     a_half;
  logic [HALF_W-1:0]     b_half;
  logic [PROD_W-1:0]     pp_aligned;
  logic [PROD_W-1:0]     rnd;
  logic [PROD_W-1:0]     rsum;
  logic [PROD_W-1:0]     rshift;
  word_t                 mag;

  assign a_abs  = a[WORD_W-1] ? -a : a;
  assign b_abs  = b[WORD_W-1] ? -b : b;
  assign a_half = cnt[1] ? ma[OPER_W-1 -: HALF_W] : ma[HALF_W-1:0];
  assign b_half = cnt[0] ? mb[OPER_W-1 -: HALF_W] : mb[HALF_W-1:0];

  always_comb begin
    case (pp_pos)
      2'd0:    pp_aligned = PROD_W'(pp);
      2'd1:    pp_aligned = PROD_W'(pp) << HALF_W;
      default: pp_aligned = PROD_W'(pp) << (2 * HALF_W);
    endcase
  end

  assign rnd    = (sh_q == '0) ? '0 : (PROD_W'(1) << (sh_q - SH_W'(1)));
  assign rsum   = acc + rnd;
  assign rshift = rsum >> sh_q;
  assign mag    = {1'b0, rshift[WORD_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      add_v    <= 1'b0;
      add_last <= 1'b0;
      fin      <= 1'b0;
      done     <= 1'b0;
    end else begin
      add_v    <= busy;
      add_last <= busy && (cnt == 2'd3);
      fin      <= add_last;
      done     <= fin;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= a_abs[OPER_W-1:0];
      mb   <= b_abs[OPER_W-1:0];
      neg  <= a[WORD_W-1] ^ b[WORD_W-1];
      sh_q <= sh;
      acc  <= '0;
    end else if (add_v) begin
      acc <= acc + pp_aligned;
    end
    if (busy) begin
      pp     <= a_half * b_half;
      pp_pos <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
    end
    if (fin) begin
      p <= neg ? -mag : mag;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy && !add_v && !fin && !done)
    else $error("Multiplier started while a product was still in progress.");

endmodule

>>> src/lssh_dp.sv
// ----------------------------------------------------------------------------
// Lowpass-scaled saturating highpass: datapath
// Holds the smoothing coefficient, the lowpass and difference state, the
// working registers and the output word, and feeds the shared multiplier.
// ----------------------------------------------------------------------------
module lssh_dp import lssh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COEF_WIDTH-1:0] cfg_data,
  input  sample_word_t          sample,
  output result_word_t          result,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  logic [COEF_WIDTH-1:0] coef;
  state_t                lp;
  state_t                perr;
  state_t                pd1;
  state_t                pd2;
  state_t                pd3;
  sample_t               x;
  logic                  last;
  word_t                 t_k;
  word_t                 t_k2;
  word_t                 t_x;
  word_t                 t_e;
  state_t                t_d;
  word_t                 acc;
  word_t                 t_res;
  result_word_t          out_q;
  word_t                 xw;
  word_t                 xs;
  word_t                 lpw;
  word_t                 mul_a;
  word_t                 mul_b;
  logic [SH_W-1:0]       mul_sh;
  word_t                 p;
  logic                  mul_done;

  function automatic word_t sext_state(input state_t v);
    return {{(WORD_W-STATE_WIDTH){v[STATE_WIDTH-1]}}, v};
  endfunction

  function automatic word_t abs_word(input word_t v);
    return v[WORD_W-1] ? -v : v;
  endfunction

  function automatic state_t sat_state(input word_t v);
    state_t r;
    if (v > STATE_MAX) begin
      r = STATE_MAX[STATE_WIDTH-1:0];
    end else if (v < STATE_MIN) begin
      r = STATE_MIN[STATE_WIDTH-1:0];
    end else begin
      r = v[STATE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic sample_t sat_sample(input word_t v);
    sample_t r;
    if (v > SAMP_MAX) begin
      r = SAMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SAMP_MIN) begin
      r = SAMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  // Rounds to nearest with ties away from zero while dropping fraction bits.
  function automatic word_t round_down(input word_t v, input int unsigned sh);
    word_t mag;
    word_t r;
    mag = abs_word(v);
    r   = (mag + (word_t'(1) <<< (sh - 1))) >>> sh;
    return v[WORD_W-1] ? -r : r;
  endfunction

  assign xw  = {{(WORD_W-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x} <<< (WORK_FRAC - SAMP_FRAC);
  assign xs  = {{(WORD_W-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x} <<< (LP_FRAC - SAMP_FRAC);
  assign lpw = sext_state(lp) <<< (WORK_FRAC - LP_FRAC);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH_W'(WORK_FRAC);
    case (cmd.op)
      OP_LP: begin
        mul_a  = xs - sext_state(lp);
        mul_b  = {{(WORD_W-COEF_WIDTH){1'b0}}, coef};
        mul_sh = SH_W'(COEF_FRAC);
      end
      OP_K: begin
        mul_a  = lpw;
        mul_b  = K_096;
        mul_sh = SH_W'(CONST_FRAC);
      end
      OP_K2: begin
        mul_a = t_k;
        mul_b = t_k;
      end
      OP_K3: begin
        mul_a = t_k2;
        mul_b = t_k;
      end
      OP_X2: begin
        mul_a = xw;
        mul_b = xw;
      end
      OP_X4: begin
        mul_a = t_x;
        mul_b = t_x;
      end
      OP_M: begin
        mul_a = t_k2;
        mul_b = t_x;
      end
      OP_E: begin
        mul_a  = t_e;
        mul_b  = K_SIXTH;
        mul_sh = SH_W'(CONST_FRAC);
      end
      OP_T2: begin
        mul_a  = abs_word(sext_state(pd2));
        mul_b  = K_D2;
        mul_sh = SH_W'(TERM_FRAC);
      end
      OP_T3: begin
        mul_a  = abs_word(sext_state(pd3));
        mul_b  = K_D3;
        mul_sh = SH_W'(TERM_FRAC);
      end
      OP_T4: begin
        mul_a  = abs_word(sext_state(t_d));
        mul_b  = K_D4;
        mul_sh = SH_W'(TERM_FRAC);
      end
      OP_RES: begin
        mul_a = xw - t_e;
        mul_b = acc;
      end
      OP_P92: begin
        mul_a  = lpw;
        mul_b  = K_092;
        mul_sh = SH_W'(CONST_FRAC);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  lssh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .p     (p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
      lp   <= '0;
      perr <= '0;
      pd1  <= '0;
      pd2  <= '0;
      pd3  <= '0;
    end else begin
      if (cfg_we) begin
        coef <= cfg_data;
      end
      if (cmd.wb && (cmd.op == OP_LP)) begin
        lp <= sat_state(sext_state(lp) + p);
      end
      if (cmd.step_en) begin
        case (cmd.step)
          STEP_D1: perr <= t_d;
          STEP_D2: pd1  <= t_d;
          STEP_D3: pd2  <= t_d;
          STEP_D4: pd3  <= t_d;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= sample.sample_in;
      last <= sample.block_last;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_K:    t_k   <= p;
        OP_K2:   t_k2  <= p;
        OP_K3:   t_k2  <= p;
        OP_X2:   t_x   <= p;
        OP_X4:   t_x   <= p;
        OP_M:    t_e   <= p;
        OP_E:    t_e   <= p;
        OP_T2:   acc   <= ONE_W + p;
        OP_T3:   acc   <= acc - p;
        OP_T4:   acc   <= acc + p;
        OP_RES:  t_res <= p;
        OP_P92:  t_res <= t_res - p;
        default: ;
      endcase
    end
    if (cmd.step_en) begin
      case (cmd.step)
        STEP_ES:  t_d <= sat_state(round_down(t_e, WORK_FRAC - ERR_FRAC));
        STEP_D1:  t_d <= sat_state(sext_state(perr) - sext_state(t_d));
        STEP_D2:  t_d <= sat_state(sext_state(pd1) - sext_state(t_d));
        STEP_D3:  t_d <= sat_state(sext_state(pd2) - sext_state(t_d));
        STEP_D4:  t_d <= sat_state(sext_state(pd3) - sext_state(t_d));
        STEP_BYP: t_res <= xw;
        STEP_OUT: begin
          out_q.sample_out <= sat_sample(round_down(t_res, WORK_FRAC - SAMP_FRAC));
          out_q.block_end  <= last;
        end
        default: ;
      endcase
    end
  end

  assign result          = out_q;
  assign status.lp_zero  = (lp == '0);
  assign status.mul_done = mul_done;

endmodule

>>> src/lssh_ctrl.sv
// ----------------------------------------------------------------------------
// Lowpass-scaled saturating highpass: controller
// Sequences the products and the register steps for one sample, and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
module lssh_ctrl import lssh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  output logic       result_valid,
  input  logic       result_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LP   = 5'd1;
  localparam logic [4:0] S_CHK  = 5'd2;
  localparam logic [4:0] S_K    = 5'd3;
  localparam logic [4:0] S_K2   = 5'd4;
  localparam logic [4:0] S_K3   = 5'd5;
  localparam logic [4:0] S_X2   = 5'd6;
  localparam logic [4:0] S_X4   = 5'd7;
  localparam logic [4:0] S_M    = 5'd8;
  localparam logic [4:0] S_E    = 5'd9;
  localparam logic [4:0] S_ES   = 5'd10;
  localparam logic [4:0] S_D1   = 5'd11;
  localparam logic [4:0] S_D2   = 5'd12;
  localparam logic [4:0] S_D3   = 5'd13;
  localparam logic [4:0] S_D4   = 5'd14;
  localparam logic [4:0] S_T2   = 5'd15;
  localparam logic [4:0] S_T3   = 5'd16;
  localparam logic [4:0] S_T4   = 5'd17;
  localparam logic [4:0] S_RES  = 5'd18;
  localparam logic [4:0] S_BYP  = 5'd19;
  localparam logic [4:0] S_P92  = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;

  logic [4:0]      state;
  logic [4:0]      state_next;
  logic            issued;
  logic            issued_next;
  logic            out_valid;
  logic            out_valid_next;
  logic [OP_W-1:0] mul_op;
  logic [4:0]      mul_next;

  assign sample_stall = (state != S_IDLE);
  assign result_valid = out_valid;

  always_comb begin
    case (state)
      S_LP:    begin mul_op = OP_LP;  mul_next = S_CHK; end
      S_K:     begin mul_op = OP_K;   mul_next = S_K2;  end
      S_K2:    begin mul_op = OP_K2;  mul_next = S_K3;  end
      S_K3:    begin mul_op = OP_K3;  mul_next = S_X2;  end
      S_X2:    begin mul_op = OP_X2;  mul_next = S_X4;  end
      S_X4:    begin mul_op = OP_X4;  mul_next = S_M;   end
      S_M:     begin mul_op = OP_M;   mul_next = S_E;   end
      S_E:     begin mul_op = OP_E;   mul_next = S_ES;  end
      S_T2:    begin mul_op = OP_T2;  mul_next = S_T3;  end
      S_T3:    begin mul_op = OP_T3;  mul_next = S_T4;  end
      S_T4:    begin mul_op = OP_T4;  mul_next = S_RES; end
      S_RES:   begin mul_op = OP_RES; mul_next = S_P92; end
      S_P92:   begin mul_op = OP_P92; mul_next = S_OUT; end
      default: begin mul_op = OP_LP;  mul_next = S_IDLE; end
    endcase
  end

  always_comb begin
    cmd            = '0;
    state_next     = state;
    issued_next    = issued;
    out_valid_next = out_valid;
    if (out_valid && !result_stall) begin
      out_valid_next = 1'b0;
    end
    if (state inside {S_LP, S_K, S_K2, S_K3, S_X2, S_X4, S_M, S_E,
                      S_T2, S_T3, S_T4, S_RES, S_P92}) begin
      cmd.op = mul_op;
      if (!issued) begin
        cmd.mul_start = 1'b1;
        issued_next   = 1'b1;
      end else if (status.mul_done) begin
        cmd.wb      = 1'b1;
        issued_next = 1'b0;
        state_next  = mul_next;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            cmd.load   = 1'b1;
            state_next = S_LP;
          end
        end
        S_CHK: begin
          state_next = status.lp_zero ? S_BYP : S_K;
        end
        S_ES: begin
          cmd.step_en = 1'b1;
          cmd.step    = STEP_ES;
          state_next  = S_D1;
        end
        S_D1: begin
          cmd.step_en = 1'b1;
          cmd.step    = STEP_D1;
          state_next  = S_D2;
        end
        S_D2: begin
          cmd.step_en = 1'b1;
          cmd.step    = STEP_D2;
          state_next  = S_D3;
        end
        S_D3: begin
          cmd.step_en = 1'b1;
          cmd.step    = STEP_D3;
          state_next  = S_D4;
        end
        S_D4: begin
          cmd.step_en = 1'b1;
          cmd.step    = STEP_D4;
          state_next  = S_T2;
        end
        S_BYP: begin
          cmd.step_en = 1'b1;
          cmd.step    = STEP_BYP;
          state_next  = S_P92;
        end
        S_OUT: begin
          if (!out_valid || !result_stall) begin
            cmd.step_en    = 1'b1;
            cmd.step       = STEP_OUT;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_stall |-> !(cmd.step_en && (cmd.step == STEP_OUT)))
    else $error("Output word overwritten while the receiver stalls.");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> issued)
    else $error("Product arrived while no product was outstanding.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall && (state == S_LP))
    else $error("Block did not start work on an accepted word.");

  a_out_publish: assert property (@(posedge clk) disable iff (rst)
    cmd.step_en && (cmd.step == STEP_OUT) |=> out_valid && (state == S_IDLE))
    else $error("Finished word was not presented on the output.");

endmodule

>>> dv/lowpass_scaled_saturating_highpass_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowpass-scaled saturating highpass unit: self-checking testbench
// A table of directed samples opens the run. It walks the full-scale values,
// the zero lowpass level and the zero coefficient, and a full-scale square
// wave at the largest coefficient, which drives the output and the
// differences into saturation. Five random phases follow at different
// smoothing coefficients. Every result word is compared with a fixed-point
// predictor; both sides insert short random idle bursts but in the last phase.
// ----------------------------------------------------------------------------
module lowpass_scaled_saturating_highpass_unit_test;
  import lssh_pkg::*;

  typedef struct packed {
    logic                  new_coef;
    logic [COEF_WIDTH-1:0] coef;
    sample_t               value;
    logic                  last;
    logic                  known;
    sample_t               known_out;
  } directed_row_t;

  localparam sample_t FULL_POS = sample_t'(SAMP_MAX);
  localparam sample_t FULL_NEG = sample_t'(SAMP_MIN);
  localparam logic [COEF_WIDTH-1:0] COEF_OFF  = '0;
  localparam logic [COEF_WIDTH-1:0] COEF_FULL = '1;
  localparam int DIRECTED_ROWS = 23;
  localparam int PHASE_ITEMS   = 110;
  localparam int DRAIN_CYCLES  = 120;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_word_t          sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_word_t          result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COEF_WIDTH-1:0] cfg_data = '0;

  directed_row_t directed_plan [DIRECTED_ROWS] = '{
    '{1'b0, COEF_OFF,  sample_t'(0),        1'b0, 1'b1, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_POS,            1'b1, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_NEG,            1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(1),        1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(-1),       1'b0, 1'b0, sample_t'(0)},
    '{1'b1, COEF_OFF,  sample_t'(4194304),  1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(-4194304), 1'b1, 1'b0, sample_t'(0)},
    '{1'b1, COEF_FULL, FULL_POS,            1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_NEG,            1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_POS,            1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_NEG,            1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_POS,            1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  FULL_NEG,            1'b1, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(0),        1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(0),        1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(0),        1'b0, 1'b1, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(0),        1'b1, 1'b1, sample_t'(0)},
    '{1'b1, COEF_OFF,  FULL_POS,            1'b0, 1'b1, FULL_POS},
    '{1'b0, COEF_OFF,  FULL_NEG,            1'b1, 1'b1, FULL_NEG},
    '{1'b0, COEF_OFF,  sample_t'(-1),       1'b0, 1'b1, sample_t'(-1)},
    '{1'b0, COEF_OFF,  sample_t'(1),        1'b1, 1'b1, sample_t'(1)},
    '{1'b1, COEF_RESET, sample_t'(-1),      1'b0, 1'b0, sample_t'(0)},
    '{1'b0, COEF_OFF,  sample_t'(1),        1'b0, 1'b0, sample_t'(0)}
  };

  logic [COEF_WIDTH-1:0] model_coef = COEF_RESET;
  state_t model_level = '0;
  state_t model_error = '0;
  state_t model_diff1 = '0;
  state_t model_diff2 = '0;
  state_t model_diff3 = '0;

  result_word_t awaited_words [$];
  sample_t prev_drawn = '0;
  logic idling = 1'b1;
  int stall_run = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int words_checked = 0;
  int saturated_words = 0;
  int settings_applied = 0;

  lowpass_scaled_saturating_highpass_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Product of two values shifted right, rounded half away from zero, with the
  // magnitude clamped at two to the power 62.
  function automatic longint rounded_product(longint a, longint b, int unsigned sh);
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [127:0] prod;
    logic         neg;
    neg   = (a < 0) != (b < 0);
    mag_a = (a < 0) ? 64'(-a) : 64'(a);
    mag_b = (b < 0) ? 64'(-b) : 64'(b);
    prod  = 128'(mag_a) * 128'(mag_b);
    if (sh > 0) begin
      prod = (prod + (128'd1 << (sh - 1))) >> sh;
    end
    if (prod > (128'd1 << 62)) begin
      prod = 128'd1 << 62;
    end
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint requantise(longint v, int from_frac, int to_frac);
    if (to_frac >= from_frac) begin
      return rounded_product(v, longint'(1) <<< (to_frac - from_frac), 0);
    end
    return rounded_product(v, 1, from_frac - to_frac);
  endfunction

  function automatic longint clamp_to(longint v, int width);
    longint lim;
    lim = longint'(1) <<< (width - 1);
    if (v > lim - 1) begin
      return lim - 1;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  function automatic result_word_t predict_highpass(sample_word_t w);
    longint x, xw, xs, lpw, k, k3, x4, e, es, d1, d2, d3, d4, gain, acc;
    result_word_t r;
    x  = longint'(signed'(w.sample_in));
    xw = requantise(x, SAMP_FRAC, WORK_FRAC);
    xs = requantise(x, SAMP_FRAC, LP_FRAC);
    model_level = state_t'(clamp_to(longint'(model_level) +
        rounded_product(xs - longint'(model_level), longint'(model_coef), COEF_FRAC),
        STATE_WIDTH));
    lpw = requantise(longint'(model_level), LP_FRAC, WORK_FRAC);
    if (model_level != 0) begin
      k   = rounded_product(lpw, longint'(K_096), CONST_FRAC);
      k3  = rounded_product(rounded_product(k, k, WORK_FRAC), k, WORK_FRAC);
      x4  = rounded_product(xw, xw, WORK_FRAC);
      x4  = rounded_product(x4, x4, WORK_FRAC);
      e   = rounded_product(rounded_product(k3, x4, WORK_FRAC), longint'(K_SIXTH),
                            CONST_FRAC);
      es  = clamp_to(requantise(e, WORK_FRAC, ERR_FRAC), STATE_WIDTH);
      d1  = clamp_to(longint'(model_error) - es, STATE_WIDTH);
      d2  = clamp_to(longint'(model_diff1) - d1, STATE_WIDTH);
      d3  = clamp_to(longint'(model_diff2) - d2, STATE_WIDTH);
      d4  = clamp_to(longint'(model_diff3) - d3, STATE_WIDTH);
      model_error = state_t'(es);
      model_diff1 = state_t'(d1);
      model_diff2 = state_t'(d2);
      model_diff3 = state_t'(d3);
      gain = (longint'(1) <<< WORK_FRAC)
           + rounded_product((d2 < 0) ? -d2 : d2, longint'(K_D2), TERM_FRAC)
           - rounded_product((d3 < 0) ? -d3 : d3, longint'(K_D3), TERM_FRAC)
           + rounded_product((d4 < 0) ? -d4 : d4, longint'(K_D4), TERM_FRAC);
      acc = rounded_product(xw - e, gain, WORK_FRAC);
    end else begin
      acc = xw;
    end
    acc = acc - rounded_product(lpw, longint'(K_092), CONST_FRAC);
    r.sample_out = sample_t'(clamp_to(requantise(acc, WORK_FRAC, SAMP_FRAC), SAMPLE_WIDTH));
    r.block_end  = w.block_last;
    return r;
  endfunction

  function automatic sample_word_t draw_sample();
    sample_word_t w;
    case ($urandom_range(0, 9))
      0: begin
        w.sample_in = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
      end
      1: begin
        w.sample_in = (prev_drawn == FULL_NEG) ? FULL_POS : -prev_drawn;
      end
      2: begin
        w.sample_in = prev_drawn;
      end
      3, 4, 5: begin
        w.sample_in = sample_t'($urandom);
      end
      default: begin
        w.sample_in = sample_t'($urandom) >>> $urandom_range(0, 20);
      end
    endcase
    w.block_last = ($urandom_range(0, 7) == 0);
    prev_drawn = w.sample_in;
    return w;
  endfunction

  task automatic send_sample(sample_word_t w, logic known, sample_t known_out);
    result_word_t want;
    if (idling && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= w;
    do @(posedge clk); while (sample_stall);
    want = predict_highpass(w);
    if (known) begin
      want.sample_out = known_out;
    end
    awaited_words.push_back(want);
    samples_sent++;
  endtask

  task automatic settle_pipeline();
    sample_valid <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
  endtask

  task automatic write_coefficient(logic [COEF_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    model_coef = value;
    settings_applied++;
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, result);
      end else begin
        want = awaited_words.pop_front();
        if (result.sample_out !== want.sample_out) begin
          mismatches++;
          $display("%0t: sample_out expected %0d, actual %0d", $time,
                   $signed(want.sample_out), $signed(result.sample_out));
        end
        if (result.block_end !== want.block_end) begin
          mismatches++;
          $display("%0t: block_end expected %b, actual %b", $time,
                   want.block_end, result.block_end);
        end
        if (want.sample_out == FULL_POS || want.sample_out == FULL_NEG) begin
          saturated_words++;
        end
        words_checked++;
      end
    end
    if (stall_run > 0) begin
      stall_run--;
      result_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    #(64'd5_000_000);
    $display("[lowpass_scaled_saturating_highpass_unit] ERROR");
    $finish;
  end

  initial begin
    logic [COEF_WIDTH-1:0] setting;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_plan[i].new_coef) begin
        settle_pipeline();
        write_coefficient(directed_plan[i].coef);
      end
      send_sample(sample_word_t'{directed_plan[i].value, directed_plan[i].last},
                  directed_plan[i].known, directed_plan[i].known_out);
    end
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: setting = COEF_WIDTH'($urandom);
        1: setting = COEF_WIDTH'($urandom_range(1, 65535));
        2: setting = COEF_FULL;
        3: setting = COEF_OFF;
        default: setting = COEF_WIDTH'($urandom);
      endcase
      settle_pipeline();
      write_coefficient(setting);
      if (phase == 4) begin
        idling = 1'b0;
      end
      repeat (PHASE_ITEMS) send_sample(draw_sample(), 1'b0, '0);
    end
    settle_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples over %0d coefficient settings; checked %0d result words.",
             samples_sent, settings_applied, words_checked);
    $display("%0d of the expected outputs sat at full scale.", saturated_words);
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("[lowpass_scaled_saturating_highpass_unit] OK");
    end else begin
      $display("[lowpass_scaled_saturating_highpass_unit] ERROR");
    end
    $finish;
  end

endmodule
